>>> sv/vr2d_pkg.sv
// ----------------------------------------------------------------------------
// vr2d_pkg
// Shared types, constants and elaboration-time functions for the 2-D vector
// rotator: item formats, angle constants and CORDIC arctangent and gain.
// ----------------------------------------------------------------------------
package vr2d_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int DATA_WIDTH = 32;
  localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  // datapath widths: vector Q.24 with growth, angle in the cells, angle before reduction
  localparam int XW  = 43;
  localparam int ZW  = 36;
  localparam int ZRW = 38;

  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic signed [ZRW-1:0] PI_Q32      = 38'sd13493037705;
  localparam logic signed [ZRW-1:0] HALF_PI_Q32 = 38'sd6746518852;
  localparam logic signed [ZRW-1:0] TWO_PI_Q32  = 38'sd26986075410;
  localparam logic signed [ZRW-1:0] FOUR_PI_Q32 = 38'sd53972150820;
  localparam logic [63:0] PI_OVER4_Q62 = 64'h3243F6A8885A308D;

  // degree scaling divides by 45 * 2^20, done as two reciprocal steps
  localparam logic [5:0]  DEG_DIV      = 6'd45;
  localparam logic [21:0] DEG_RECIP_HI = 22'd2982617;
  localparam logic [27:0] DEG_RECIP_LO = 28'd190887436;

  localparam logic signed [31:0] SAT_MAX = {{(33-SAT_W){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic signed [31:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] rot_angle;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               clipped;
  } rsp_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // arctangent of 2^-idx in Q.32, taylor series in Q.62
  function automatic logic [63:0] atan_q32(input int idx);
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
    int          p;
    s = '0;
    if (idx == 0) begin
      return (PI_OVER4_Q62 + (64'd1 << 29)) >> 30;
    end
    for (int k = 0; k < 32; k++) begin
      p = idx * (2 * k + 1);
      if (p <= 62) begin
        den  = 64'(2 * k + 1);
        num  = 64'd1 << (62 - p);
        term = '0;
        rem  = '0;
        for (int b = 63; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          if (rem >= den) begin
            rem     = rem - den;
            term[b] = 1'b1;
          end
        end
        if (k[0]) begin
          s = s - term;
        end else begin
          s = s + term;
        end
      end
    end
    return (s + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] b;
    n = n_in;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // squared CORDIC gain in Q.62
  function automatic logic [63:0] gain_p(input int stages);
    logic [63:0] p;
    p = 64'd1 << 62;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    return p;
  endfunction

endpackage

>>> sv/vr2d_front.sv
// ----------------------------------------------------------------------------
// vr2d_front
// Angle front end: unit conversion, reduction to [-pi, pi], quadrant fold and
// scaling of the vector into the cordic format.
// ----------------------------------------------------------------------------
module vr2d_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              deg,
  input  logic              up_valid,
  output logic              up_ready,
  input  vr2d_pkg::req_t    up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output vr2d_pkg::cordic_t dn_data
);

  localparam int NS  = 10;
  localparam int XW  = vr2d_pkg::XW;
  localparam int ZW  = vr2d_pkg::ZW;
  localparam int ZRW = vr2d_pkg::ZRW;

  logic [NS-1:0] vld;
  logic [NS-1:0] vin;
  logic [NS:0]   rdy;

  logic [31:0] a_u;
  logic signed [31:0] xr [0:8];
  logic signed [31:0] yr [0:8];
  logic deg_r [0:4];
  logic neg_r [0:4];
  logic signed [ZRW-1:0] zrad_r [0:4];

  logic [31:0] mag0;
  logic [62:0] p1;
  logic [20:0] nh2;
  logic [20:0] nl2;
  logic [15:0] qh2;
  logic [15:0] qh3;
  logic [26:0] m3;
  logic [36:0] q4;
  logic signed [ZRW-1:0] z5;
  logic signed [ZRW-1:0] z6;
  logic signed [ZRW-1:0] z7;
  logic signed [ZRW-1:0] z8;

  logic [42:0] prod1;
  logic [21:0] t45;
  logic [21:0] rh_full;
  logic [54:0] prod2;
  logic signed [ZRW-1:0] qx;
  logic signed [ZRW-1:0] zf;
  logic                  flip;
  logic signed [XW-1:0]  xs;
  logic signed [XW-1:0]  ys;

  // stage handshake
  assign vin      = {vld[NS-2:0], up_valid};
  assign rdy[NS]  = dn_ready;
  assign up_ready = rdy[0];
  assign dn_valid = vld[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_hs
    assign rdy[k] = !vld[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vin[k];
      end
    end
  end

  assign a_u = up_data.rot_angle;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xr[0]     <= up_data.in_x;
      yr[0]     <= up_data.in_y;
      deg_r[0]  <= deg;
      neg_r[0]  <= a_u[31];
      mag0      <= a_u[31] ? (~a_u + 32'd1) : a_u;
      zrad_r[0] <= {a_u[31], a_u, 5'd0};
    end
  end

  for (genvar k = 1; k < 9; k++) begin : g_xy
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        xr[k] <= xr[k-1];
        yr[k] <= yr[k-1];
      end
    end
  end

  for (genvar k = 1; k < 5; k++) begin : g_ang
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        deg_r[k]  <= deg_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        zrad_r[k] <= zrad_r[k-1];
      end
    end
  end

  // degree magnitude times pi
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p1 <= {31'd0, mag0} * {32'd0, vr2d_pkg::PI_Q29};
    end
  end

  // divide by 2^20 then by 45, upper half first
  assign prod1 = {22'd0, p1[61:41]} * {21'd0, vr2d_pkg::DEG_RECIP_HI};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      nh2 <= p1[61:41];
      nl2 <= p1[40:20];
      qh2 <= prod1[42:27];
    end
  end

  assign t45     = {6'd0, qh2} * {16'd0, vr2d_pkg::DEG_DIV};
  assign rh_full = {1'b0, nh2} - t45;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      qh3 <= qh2;
      m3  <= {rh_full[5:0], nl2};
    end
  end

  assign prod2 = {28'd0, m3} * {27'd0, vr2d_pkg::DEG_RECIP_LO};

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      q4 <= {qh3, prod2[53:33]};
    end
  end

  assign qx = {1'b0, q4};

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      z5 <= deg_r[4] ? (neg_r[4] ? -qx : qx) : zrad_r[4];
    end
  end

  // truncated modulo 2*pi, quotient is at most two
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      if (z5 >= vr2d_pkg::FOUR_PI_Q32) begin
        z6 <= z5 - vr2d_pkg::FOUR_PI_Q32;
      end else if (z5 <= -vr2d_pkg::FOUR_PI_Q32) begin
        z6 <= z5 + vr2d_pkg::FOUR_PI_Q32;
      end else begin
        z6 <= z5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      if (z6 >= vr2d_pkg::TWO_PI_Q32) begin
        z7 <= z6 - vr2d_pkg::TWO_PI_Q32;
      end else if (z6 <= -vr2d_pkg::TWO_PI_Q32) begin
        z7 <= z6 + vr2d_pkg::TWO_PI_Q32;
      end else begin
        z7 <= z6;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      if (z7 > vr2d_pkg::PI_Q32) begin
        z8 <= z7 - vr2d_pkg::TWO_PI_Q32;
      end else if (z7 < -vr2d_pkg::PI_Q32) begin
        z8 <= z7 + vr2d_pkg::TWO_PI_Q32;
      end else begin
        z8 <= z7;
      end
    end
  end

  // fold into the right half plane
  always_comb begin
    if (z8 > vr2d_pkg::HALF_PI_Q32) begin
      flip = 1'b1;
      zf   = z8 - vr2d_pkg::PI_Q32;
    end else if (z8 < -vr2d_pkg::HALF_PI_Q32) begin
      flip = 1'b1;
      zf   = z8 + vr2d_pkg::PI_Q32;
    end else begin
      flip = 1'b0;
      zf   = z8;
    end
  end

  assign xs = {{(XW-40){xr[8][31]}}, xr[8], 8'd0};
  assign ys = {{(XW-40){yr[8][31]}}, yr[8], 8'd0};

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      dn_data.x <= flip ? -xs : xs;
      dn_data.y <= flip ? -ys : ys;
      dn_data.z <= zf[ZW-1:0];
    end
  end

endmodule

>>> sv/vr2d_cell.sv
// ----------------------------------------------------------------------------
// vr2d_cell
// One cordic micro-rotation with its own valid bit and stall handling.
// ----------------------------------------------------------------------------
module vr2d_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  vr2d_pkg::cordic_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output vr2d_pkg::cordic_t dn_data
);

  localparam int XW = vr2d_pkg::XW;
  localparam int ZW = vr2d_pkg::ZW;
  localparam logic [63:0] ATAN_FULL = vr2d_pkg::atan_q32(IDX);
  localparam logic signed [ZW-1:0] ATAN = ATAN_FULL[ZW-1:0];

  logic signed [XW-1:0] xi;
  logic signed [XW-1:0] yi;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] zi;

  assign xi = up_data.x;
  assign yi = up_data.y;
  assign zi = up_data.z;
  assign dx = yi >>> IDX;
  assign dy = xi >>> IDX;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      if (!zi[ZW-1]) begin
        dn_data.x <= xi - dx;
        dn_data.y <= yi + dy;
        dn_data.z <= zi - ATAN;
      end else begin
        dn_data.x <= xi + dx;
        dn_data.y <= yi - dy;
        dn_data.z <= zi + ATAN;
      end
    end
  end

endmodule

>>> sv/vr2d_gain.sv
// ----------------------------------------------------------------------------
// vr2d_gain
// Gain compensation, rounding to Q16.16 and saturation; holds the result item.
// ----------------------------------------------------------------------------
module vr2d_gain #(
  parameter int STAGES = vr2d_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  vr2d_pkg::cordic_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output vr2d_pkg::rsp_t    dn_data
);

  localparam int XW = vr2d_pkg::XW;
  localparam int PW = XW + 17;
  localparam int TW = PW + 1;
  localparam int RW = TW - 24;
  localparam logic [63:0] GAIN_K =
    (64'd1 << 63) / vr2d_pkg::isqrt64(vr2d_pkg::gain_p(STAGES));
  localparam logic [15:0] K_HI = GAIN_K[31:16];
  localparam logic [15:0] K_LO = GAIN_K[15:0];
  localparam logic signed [TW-1:0] RND = {{(TW-24){1'b0}}, 1'b1, 23'd0};

  logic [2:0] vld;
  logic [2:0] vin;
  logic [3:0] rdy;

  logic signed [XW-1:0] xi;
  logic signed [XW-1:0] yi;
  logic signed [PW-1:0] phx;
  logic signed [PW-1:0] plx;
  logic signed [PW-1:0] phy;
  logic signed [PW-1:0] ply;
  logic signed [TW-1:0] tx;
  logic signed [TW-1:0] ty;
  logic signed [TW-1:0] sx;
  logic signed [TW-1:0] sy;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  logic [32:0] cx;
  logic [32:0] cy;

  function automatic logic [32:0] clamp(input logic signed [RW-1:0] r);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = RW'(vr2d_pkg::SAT_MAX);
    lo = RW'(vr2d_pkg::SAT_MIN);
    if (r > hi) begin
      return {1'b1, hi[31:0]};
    end else if (r < lo) begin
      return {1'b1, lo[31:0]};
    end
    return {1'b0, r[31:0]};
  endfunction

  assign vin      = {vld[1:0], up_valid};
  assign rdy[3]   = dn_ready;
  assign up_ready = rdy[0];
  assign dn_valid = vld[2];

  for (genvar k = 0; k < 3; k++) begin : g_hs
    assign rdy[k] = !vld[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vin[k];
      end
    end
  end

  assign xi = up_data.x;
  assign yi = up_data.y;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      phx <= PW'(xi * $signed({1'b0, K_HI}));
      plx <= PW'(xi * $signed({1'b0, K_LO}));
      phy <= PW'(yi * $signed({1'b0, K_HI}));
      ply <= PW'(yi * $signed({1'b0, K_LO}));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      tx <= TW'(phx) + TW'(plx >>> 16);
      ty <= TW'(phy) + TW'(ply >>> 16);
    end
  end

  assign sx = tx + RND;
  assign sy = ty + RND;
  assign rx = $signed(sx[TW-1:24]);
  assign ry = $signed(sy[TW-1:24]);
  assign cx = clamp(rx);
  assign cy = clamp(ry);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dn_data.out_x   <= cx[31:0];
      dn_data.out_y   <= cy[31:0];
      dn_data.clipped <= cx[32] | cy[32];
    end
  end

endmodule

>>> sv/vector_rotation_2d.sv
// ----------------------------------------------------------------------------
// vector_rotation_2d
// Rotates a Q16.16 vector counter-clockwise by a radian or degree angle with a
// pipelined, gain-compensated cordic and saturates the result.
//
//   channel  signals                     payload
//   cfg      cfg_valid / cfg_ready       cfg_data: angle unit, 1 = degrees
//   req      req_valid / req_ready       req: in_x, in_y, rot_angle
//   rsp      rsp_valid / rsp_ready       rsp: out_x, out_y, clipped
//
// one item per cycle while rsp_ready stays high; ten angle stages,
// one cell per micro-rotation, three gain and saturation stages
// every stage has its own valid bit, so a stalled result only holds the stages
// behind it and bubbles keep filling
// reset clears the valid bits and the angle unit register
// ----------------------------------------------------------------------------
module vector_rotation_2d #(
  parameter int CORDIC_STAGES = vr2d_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           req_valid,
  output logic           req_ready,
  input  vr2d_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output vr2d_pkg::rsp_t rsp
);

  logic angle_in_degrees;

  vr2d_pkg::cordic_t          chain_data [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0]     chain_valid;
  logic [CORDIC_STAGES:0]     chain_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_in_degrees <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      angle_in_degrees <= cfg_data;
    end
  end

  vr2d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .deg      (angle_in_degrees),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_data  (req),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    vr2d_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  vr2d_gain #(
    .STAGES (CORDIC_STAGES)
  ) u_gain (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[CORDIC_STAGES]),
    .up_ready (chain_ready[CORDIC_STAGES]),
    .up_data  (chain_data[CORDIC_STAGES]),
    .dn_valid (rsp_valid),
    .dn_ready (rsp_ready),
    .dn_data  (rsp)
  );

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.clipped |->
      rsp.out_x == vr2d_pkg::SAT_MAX || rsp.out_x == vr2d_pkg::SAT_MIN ||
      rsp.out_y == vr2d_pkg::SAT_MAX || rsp.out_y == vr2d_pkg::SAT_MIN)
    else $error("clipped item without a saturated component");

  a_empty_takes_item: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("input stalled while result slot is empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result item present after reset");

endmodule

>>> test/tb_vector_rotation_2d.sv
// ----------------------------------------------------------------------------
// tb_vector_rotation_2d
// Self-checking bench for the 2-D vector rotator. A queue of vectors feeds a
// valid/ready driver; every accepted item is run through a bit-exact CORDIC
// model and the expected rotation is queued. The monitor compares each result
// field by field. Phases alternate the angle unit (radians, degrees) and the
// sender/receiver idle rates, starting with directed corner vectors and
// angles, then random ones.
// ----------------------------------------------------------------------------
module tb_vector_rotation_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES         = vr2d_pkg::CORDIC_STAGES_DEF;
  localparam int PIPE_LATENCY   = STAGES + 13;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 410;

  localparam longint ANG_PI      = 64'sd13493037705;
  localparam longint ANG_HALF_PI = 64'sd6746518852;
  localparam longint PI_Q29_ANG  = 64'sd1686629713;
  localparam longint DEG_DIVISOR = 64'sd47185920;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;

  localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [31:0] QUARTER_RAD = 32'sd105414357;
  localparam logic signed [31:0] HALF_RAD    = 32'sd210828714;
  localparam logic signed [31:0] PI_RAD      = 32'sd421657428;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  vr2d_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  vr2d_pkg::rsp_t rsp;

  vr2d_pkg::req_t pending_vectors[$];
  vr2d_pkg::rsp_t expected_rotations[$];
  longint atan_tab[STAGES];
  longint unsigned gain_k;
  bit deg_mode = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;

  vector_rotation_2d u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  function automatic longint arctan_q32(int idx);
    longint unsigned acc;
    longint unsigned term;
    int p;
    acc = '0;
    if (idx == 0) begin
      return longint'((QUARTER_PI_Q62 + (64'd1 << 29)) >> 30);
    end
    for (int k = 0; k < 64; k++) begin
      p = idx * (2 * k + 1);
      if (p > 62) begin
        break;
      end
      term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return longint'((acc + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = '0;
    b = 64'd1 << 62;
    while (b > n) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cordic_gain_inv();
    longint unsigned p;
    p = 64'd1 << 62;
    for (int i = 0; i < STAGES && 2 * i < 64; i++) begin
      p = p + (p >> (2 * i));
    end
    return 64'h8000_0000_0000_0000 / int_sqrt(p);
  endfunction

  function automatic longint scale_by_gain(longint v);
    longint k_hi;
    longint k_lo;
    longint t;
    k_hi = longint'(gain_k >> 16);
    k_lo = longint'(gain_k & 64'hFFFF);
    t = v * k_hi + ((v * k_lo) >>> 16);
    return (t + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v, inout bit hit);
    if (v > longint'(MAX32)) begin
      hit = 1'b1;
      return MAX32;
    end
    if (v < longint'(MIN32)) begin
      hit = 1'b1;
      return MIN32;
    end
    return v[31:0];
  endfunction

  function automatic vr2d_pkg::rsp_t rotate_vector(vr2d_pkg::req_t v, bit deg);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    vr2d_pkg::rsp_t o;
    bit hit;
    hit = 1'b0;
    x = longint'(v.in_x) * 256;
    y = longint'(v.in_y) * 256;
    if (deg) begin
      z = (longint'(v.rot_angle) * PI_Q29_ANG) / DEG_DIVISOR;
    end else begin
      z = longint'(v.rot_angle) * 32;
    end
    // reduce to [-pi, pi], then fold into [-pi/2, pi/2]
    z = z % (2 * ANG_PI);
    if (z > ANG_PI) begin
      z = z - 2 * ANG_PI;
    end
    if (z < -ANG_PI) begin
      z = z + 2 * ANG_PI;
    end
    if (z > ANG_HALF_PI) begin
      x = -x;
      y = -y;
      z = z - ANG_PI;
    end else if (z < -ANG_HALF_PI) begin
      x = -x;
      y = -y;
      z = z + ANG_PI;
    end
    for (int i = 0; i < STAGES && i < 63; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    o.out_x = clamp32(scale_by_gain(x), hit);
    o.out_y = clamp32(scale_by_gain(y), hit);
    o.clipped = hit;
    return o;
  endfunction

  function automatic vr2d_pkg::req_t make_vec(logic signed [31:0] x,
                                              logic signed [31:0] y,
                                              logic signed [31:0] a);
    vr2d_pkg::req_t v;
    v.in_x = x;
    v.in_y = y;
    v.rot_angle = a;
    return v;
  endfunction

  // random magnitude spread over all bit positions, both signs
  function automatic logic signed [31:0] rand_field();
    return $signed($urandom) >>> $urandom_range(31);
  endfunction

  function automatic logic signed [31:0] deg_q21(int d);
    return 32'(d) <<< 21;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_rotations.push_back(rotate_vector(req, deg_mode));
      end
      if (!req_valid || req_ready) begin
        if (pending_vectors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= pending_vectors.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vr2d_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rotations.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("unexpected item: x=%0d y=%0d clipped=%0b",
                     rsp.out_x, rsp.out_y, rsp.clipped);
          end
        end else begin
          want = expected_rotations.pop_front();
          if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
              rsp.clipped !== want.clipped) begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: expected x=%0d y=%0d clipped=%0b, got x=%0d y=%0d clipped=%0b",
                       want.out_x, want.out_y, want.clipped,
                       rsp.out_x, rsp.out_y, rsp.clipped);
            end
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_angle_unit(input bit deg);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= deg;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    deg_mode = deg;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_vectors.size() != 0 || req_valid || expected_rotations.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < STAGES; i++) begin
      atan_tab[i] = arctan_q32(i);
    end
    gain_k = cordic_gain_inv();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      write_angle_unit(phase[0]);
      @(negedge clk);
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
        end
      endcase
      if (phase == 0) begin
        // radian corners: zero, full scale, fold and wrap boundaries, saturation
        pending_vectors.push_back(make_vec(0, 0, 0));
        pending_vectors.push_back(make_vec(MAX32, MAX32, 0));
        pending_vectors.push_back(make_vec(MIN32, MIN32, 0));
        pending_vectors.push_back(make_vec(MAX32, MAX32, QUARTER_RAD));
        pending_vectors.push_back(make_vec(MIN32, MAX32, -QUARTER_RAD));
        pending_vectors.push_back(make_vec(ONE_Q16, 0, HALF_RAD));
        pending_vectors.push_back(make_vec(ONE_Q16, 0, HALF_RAD + 1));
        pending_vectors.push_back(make_vec(0, ONE_Q16, -HALF_RAD));
        pending_vectors.push_back(make_vec(0, ONE_Q16, -HALF_RAD - 1));
        pending_vectors.push_back(make_vec(ONE_Q16, ONE_Q16, PI_RAD));
        pending_vectors.push_back(make_vec(ONE_Q16, ONE_Q16, PI_RAD + 1));
        pending_vectors.push_back(make_vec(-ONE_Q16, ONE_Q16, -PI_RAD));
        pending_vectors.push_back(make_vec(-ONE_Q16, ONE_Q16, -PI_RAD - 1));
        pending_vectors.push_back(make_vec(MIN32, MAX32, MAX32));
        pending_vectors.push_back(make_vec(MAX32, MIN32, MIN32));
        pending_vectors.push_back(make_vec(-1, 1, 1));
      end else if (phase == 1) begin
        // degree corners
        pending_vectors.push_back(make_vec(ONE_Q16, 0, deg_q21(90)));
        pending_vectors.push_back(make_vec(0, ONE_Q16, deg_q21(180)));
        pending_vectors.push_back(make_vec(ONE_Q16, -ONE_Q16, deg_q21(-180)));
        pending_vectors.push_back(make_vec(MAX32, MAX32, deg_q21(45)));
        pending_vectors.push_back(make_vec(ONE_Q16, ONE_Q16, deg_q21(360)));
        pending_vectors.push_back(make_vec(MIN32, MIN32, MAX32));
        pending_vectors.push_back(make_vec(MAX32, 0, MIN32));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_vectors.push_back(make_vec(rand_field(), rand_field(), rand_field()));
      end
      wait_drained();
    end

    if (expected_rotations.size() != 0) begin
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> vector_rotation_2d.f
sv/vr2d_pkg.sv
sv/vr2d_front.sv
sv/vr2d_cell.sv
sv/vr2d_gain.sv
sv/vector_rotation_2d.sv
test/tb_vector_rotation_2d.sv
